// ===== sv/bec_pkg.sv =====
// Shared types, event codes and constants for the button event classifier.
// No dependencies; every other file imports this package.
package bec_pkg;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned NSLOTS      = 11;
  localparam int unsigned SLOT_W      = $clog2(NSLOTS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RST       = 16'd200;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd200;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [CFG_W-1:0]  cfg_val_t;
  typedef logic [NSLOTS-1:0] ev_mask_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_REPEAT       = 2'd1,
    REG_DOUBLE_CLICK = 2'd2
  } reg_idx_t;

  typedef enum logic [CODE_W-1:0] {
    EV_PRESSED      = 4'd0,
    EV_CHANGED      = 4'd1,
    EV_PRESSING     = 4'd2,
    EV_LONG         = 4'd3,
    EV_LONG_REPEAT  = 4'd4,
    EV_DOUBLE       = 4'd5,
    EV_LONG_RELEASE = 4'd6,
    EV_SHORT        = 4'd7,
    EV_CLICKED      = 4'd8,
    EV_RELEASED     = 4'd9
  } event_code_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HELD = 2'd1,
    MODE_LONG = 2'd2
  } mode_t;

  // Slots of a request mask, in emission order
  localparam int unsigned SL_PRESSED      = 0;
  localparam int unsigned SL_CHANGED_DN   = 1;
  localparam int unsigned SL_PRESSING     = 2;
  localparam int unsigned SL_LONG         = 3;
  localparam int unsigned SL_LONG_REPEAT  = 4;
  localparam int unsigned SL_DOUBLE       = 5;
  localparam int unsigned SL_LONG_RELEASE = 6;
  localparam int unsigned SL_SHORT        = 7;
  localparam int unsigned SL_CLICKED      = 8;
  localparam int unsigned SL_RELEASED     = 9;
  localparam int unsigned SL_CHANGED_UP   = 10;

  // One push from the front into the queue
  typedef struct packed {
    logic     valid;
    ev_mask_t mask;
  } bec_push_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    ev_mask_t mask;
  } bec_head_t;

  function automatic event_code_t slot_code(input slot_t slot);
    event_code_t c;
    case (slot)
      4'd0:    c = EV_PRESSED;
      4'd1:    c = EV_CHANGED;
      4'd2:    c = EV_PRESSING;
      4'd3:    c = EV_LONG;
      4'd4:    c = EV_LONG_REPEAT;
      4'd5:    c = EV_DOUBLE;
      4'd6:    c = EV_LONG_RELEASE;
      4'd7:    c = EV_SHORT;
      4'd8:    c = EV_CLICKED;
      4'd9:    c = EV_RELEASED;
      4'd10:   c = EV_CHANGED;
      default: c = EV_CHANGED;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/bec_front.sv =====
// Front end: config registers, button state and per-scan event classification.
// Produces one request mask per scan that causes events. Depends on bec_pkg.
module bec_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_pressed,
  input  logic [31:0]           in_now_ms,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  q_full,
  output bec_pkg::bec_push_t    push
);
  import bec_pkg::*;

  cfg_val_t long_ms_r, repeat_ms_r, dbl_ms_r;
  mode_t    mode_r, mode_nxt;
  logic     latched_r, latched_nxt;
  tick_t    press_stamp_r, press_stamp_nxt;
  tick_t    long_stamp_r, long_stamp_nxt;
  tick_t    click_stamp_r, click_stamp_nxt;

  logic     accept;
  tick_t    held_t, since_long, since_click;
  ev_mask_t mask;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ms_r   <= LONG_PRESS_RST;
      repeat_ms_r <= REPEAT_RST;
      dbl_ms_r    <= DOUBLE_CLICK_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LONG_PRESS:   long_ms_r   <= cfg_data;
        REG_REPEAT:       repeat_ms_r <= cfg_data;
        REG_DOUBLE_CLICK: dbl_ms_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    latched_nxt     = latched_r;
    press_stamp_nxt = press_stamp_r;
    long_stamp_nxt  = long_stamp_r;
    click_stamp_nxt = click_stamp_r;
    mask            = '0;
    // on the press scan itself the hold time is zero
    held_t      = (in_pressed && mode_r == MODE_IDLE) ? '0 : (in_now_ms - press_stamp_r);
    since_long  = in_now_ms - long_stamp_r;
    since_click = in_now_ms - click_stamp_r;

    if (in_pressed) begin
      if (mode_r == MODE_IDLE) begin
        press_stamp_nxt        = in_now_ms;
        mask[SL_PRESSED]       = 1'b1;
        mask[SL_CHANGED_DN]    = 1'b1;
      end
      mode_nxt           = (mode_r == MODE_IDLE) ? MODE_HELD : mode_r;
      mask[SL_PRESSING]  = 1'b1;
      if (held_t >= {16'd0, long_ms_r}) begin
        mode_nxt = MODE_LONG;
        if (!latched_r) begin
          mask[SL_LONG]  = 1'b1;
          long_stamp_nxt = in_now_ms;
          latched_nxt    = 1'b1;
        end else if (since_long >= {16'd0, repeat_ms_r}) begin
          mask[SL_LONG_REPEAT] = 1'b1;
          long_stamp_nxt       = in_now_ms;
        end
      end
    end else if (mode_r != MODE_IDLE) begin
      mode_nxt              = MODE_IDLE;
      mask[SL_DOUBLE]       = since_click < {16'd0, dbl_ms_r};
      mask[SL_LONG_RELEASE] = latched_r;
      latched_nxt           = 1'b0;
      click_stamp_nxt       = in_now_ms;
      mask[SL_SHORT]        = held_t < {16'd0, long_ms_r};
      mask[SL_CLICKED]      = 1'b1;
      mask[SL_RELEASED]     = 1'b1;
      mask[SL_CHANGED_UP]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      latched_r     <= 1'b0;
      press_stamp_r <= '0;
      long_stamp_r  <= '0;
      click_stamp_r <= '0;
    end else if (accept) begin
      mode_r        <= mode_nxt;
      latched_r     <= latched_nxt;
      press_stamp_r <= press_stamp_nxt;
      long_stamp_r  <= long_stamp_nxt;
      click_stamp_r <= click_stamp_nxt;
    end
  end

  // idle scans push nothing
  assign push.valid = accept && (mask != '0);
  assign push.mask  = mask;

endmodule

// ===== sv/bec_queue.sv =====
// Short request queue between front and back end.
// Depends on bec_pkg.
module bec_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  bec_pkg::bec_push_t  push,
  input  logic                pop,
  output logic                full,
  output bec_pkg::bec_head_t  head
);
  import bec_pkg::*;

  ev_mask_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head.valid = count_r != '0;
  assign head.mask  = mem[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.mask;
    end
  end

  always_comb begin
    count_nxt = count_r;
    case ({push.valid, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)     rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/bec_back.sv =====
// Back end: walks one request mask a slot at a time into the output register.
// Depends on bec_pkg.
module bec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bec_pkg::bec_head_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_event_code,
  output logic                out_last_event
);
  import bec_pkg::*;

  ev_mask_t    cur_r, cur_nxt, rest;
  logic        out_valid_r, out_valid_nxt;
  event_code_t code_r;
  logic        last_r;
  slot_t       slot;
  logic        load;

  always_comb begin
    slot = '0;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (cur_r[i]) slot = slot_t'(i);
    end
  end

  assign rest = cur_r & (cur_r - 1'b1);
  assign load = (cur_r != '0) && (!out_valid_r || !out_stall);
  // fetch a new request once the current one is used up
  assign pop  = (cur_r == '0) || (load && rest == '0);

  always_comb begin
    if (pop && head.valid) cur_nxt = head.mask;
    else if (load)         cur_nxt = rest;
    else                   cur_nxt = cur_r;
    if (load)              out_valid_nxt = 1'b1;
    else if (out_stall)    out_valid_nxt = out_valid_r;
    else                   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= slot_code(slot);
      last_r <= rest == '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = code_r;
  assign out_last_event = last_r;

endmodule

// ===== sv/button_event_classifier.sv =====
// A scan's first event passes the request queue, the current-mask register and the output
// register. Throughput: one scan per cycle into the front while the queue is not full; the
// back end shows one event per cycle unless stalled. A scan yields 0 to 6 events, idle scans
// none. A 4-entry request queue absorbs bursts. Reset (rst_n low, synchronous) restores the
// register defaults 500/200/200, clears button state, queue and output; no clearing pass.
module button_event_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_pressed,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_code,
  output logic        out_last_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bec_pkg::*;

  bec_push_t push;
  bec_head_t head;
  logic      q_full;
  logic      pop;

  assign cfg_ready = 1'b1;

  bec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pressed(in_pressed),
    .in_now_ms (in_now_ms),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push)
  );

  bec_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  bec_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_code(out_event_code),
    .out_last_event(out_last_event)
  );

endmodule

// ===== sv/bec_checker.sv =====
// Port-level checks for button_event_classifier, bound to the top level.
// Depends on bec_pkg.
module bec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_event_code,
  input logic        out_last_event
);
  import bec_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code)
      && $stable(out_last_event))
    else $error("result changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= EV_RELEASED)
    else $error("event code out of range");

  a_pressed_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == EV_PRESSED || out_event_code == EV_RELEASED)
      |-> !out_last_event)
    else $error("press or release flagged as last event");

  a_click_then_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_event_code == EV_CLICKED
      |=> out_valid && out_event_code == EV_RELEASED)
    else $error("click not followed by release");

endmodule

bind button_event_classifier bec_checker u_bec_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_event_code(out_event_code),
  .out_last_event(out_last_event)
);
